// ----- hw/rtl/zrd_pkg.sv -----
`timescale 1ns / 1ps
package zrd_pkg;

  localparam int unsigned SAMPLE_W    = 32;
  localparam int unsigned COUNT_W     = 16;
  localparam int unsigned K_W         = 5;
  localparam int unsigned HEADER_BITS = 5;
  localparam int unsigned K_MAX       = 31;
  localparam int unsigned ZONED_MIN   = 64;
  localparam int unsigned MAX_RESULTS = 32;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_SEG_LEN   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ZONE_MODE = 1'd1;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                overflow;
  } value_t;

endpackage

// ----- hw/rtl/zrd_stream_if.sv -----
`timescale 1ns / 1ps
interface zrd_stream_if #(
  parameter int unsigned WORD_BITS = 32
);
  logic                 valid;
  logic                 ready;
  logic [WORD_BITS-1:0] stream_word;
  logic                 restart;

  modport source (output valid, output stream_word, output restart, input ready);
  modport sink   (input valid, input stream_word, input restart, output ready);
endinterface

// ----- hw/rtl/zrd_result_if.sv -----
`timescale 1ns / 1ps
interface zrd_result_if;
  logic                                valid;
  logic                                ready;
  logic signed [zrd_pkg::SAMPLE_W-1:0] sample;
  logic [zrd_pkg::COUNT_W-1:0]         repeat_count;
  logic                                segment_end;
  logic                                decode_error;

  modport source (output valid, output sample, output repeat_count, output segment_end,
                  output decode_error, input ready);
  modport sink   (input valid, input sample, input repeat_count, input segment_end,
                  input decode_error, output ready);
endinterface

// ----- hw/rtl/zrd_value_unit.sv -----
`timescale 1ns / 1ps
module zrd_value_unit #(
  parameter int unsigned ZONE_COUNT = 8,
  parameter int unsigned START_W    = 35
) (
  input  logic [zrd_pkg::SAMPLE_W-1:0] unary_i,
  input  logic [zrd_pkg::K_W-1:0]      k_i,
  input  logic [START_W-1:0]           start_i,
  input  logic [zrd_pkg::SAMPLE_W-1:0] literal_i,
  output zrd_pkg::value_t              value_o
);
  localparam int unsigned VW = 2 * zrd_pkg::SAMPLE_W;

  logic [zrd_pkg::SAMPLE_W-1:0] escape;
  logic [VW-1:0]                shifted;
  logic [VW-1:0]                total;
  logic [zrd_pkg::SAMPLE_W-1:0] lo;

  // escape part only beyond the last zone
  always_comb begin
    if (unary_i < zrd_pkg::SAMPLE_W'(ZONE_COUNT)) begin
      escape = '0;
    end else begin
      escape = unary_i - zrd_pkg::SAMPLE_W'(ZONE_COUNT) + 1'b1;
    end
    shifted = {{zrd_pkg::SAMPLE_W{1'b0}}, escape} << k_i;
    total   = shifted + VW'(start_i) + VW'(literal_i);
    lo      = total[zrd_pkg::SAMPLE_W-1:0];
    value_o.sample   = (lo >> 1) ^ {zrd_pkg::SAMPLE_W{lo[0]}};
    value_o.overflow = |total[VW-1:zrd_pkg::SAMPLE_W];
  end
endmodule

// ----- hw/rtl/zoned_rice_decoder.sv -----
`timescale 1ns / 1ps
// bit-serial rice decoder: one stream bit per cycle while a word is held and decode is not stalled;
// each decoded sample adds an emit step and each coded header a pass over the zones for their start
// codes; ready only when the previous word is fully consumed and neither pass nor emit step runs;
// a sample result is loaded by the emit step after its last bit, a silence result at the edge of its
// last header bit; results sit in an output register so decode runs on while one waits for a transfer
// a full output register stalls another load; rst_ni clears all control state and the zone tables
module zoned_rice_decoder #(
  parameter int unsigned ZONE_COUNT = 8,
  parameter int unsigned WORD_BITS  = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [zrd_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [zrd_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  zrd_stream_if.sink                        stream_i,
  zrd_result_if.source                      result_o
);
  localparam int unsigned ZW      = $clog2(ZONE_COUNT);
  localparam int unsigned START_W = zrd_pkg::SAMPLE_W + ZW;
  localparam int unsigned CNT_W   = $clog2(WORD_BITS + 1);
  localparam int unsigned SW      = zrd_pkg::SAMPLE_W;
  localparam int unsigned KW      = zrd_pkg::K_W;
  localparam int unsigned NW      = $clog2(zrd_pkg::MAX_RESULTS + 1);

  // decode phases
  localparam logic [2:0] PH_HEADER      = 3'd0;
  localparam logic [2:0] PH_ZONE_ONES   = 3'd1;
  localparam logic [2:0] PH_ZONE_SECOND = 3'd2;
  localparam logic [2:0] PH_UNARY       = 3'd3;
  localparam logic [2:0] PH_LITERAL     = 3'd4;
  localparam logic [2:0] PH_FINISH      = 3'd5;
  localparam logic [2:0] PH_EMIT        = 3'd6;

  // configuration
  logic [zrd_pkg::COUNT_W-1:0] seg_len_q;
  logic                        zone_mode_q;

  // decode state
  logic [2:0]                  phase_q, phase_d;
  logic [KW-1:0]               ktab_q [ZONE_COUNT];
  logic [KW-1:0]               ktab_d [ZONE_COUNT];
  logic [START_W-1:0]          start_q [ZONE_COUNT];
  logic [START_W-1:0]          start_d [ZONE_COUNT];
  logic [SW-1:0]               unary_q, unary_d;
  logic [SW-1:0]               lit_q, lit_d;
  logic [KW-1:0]               lidx_q, lidx_d;
  logic [zrd_pkg::COUNT_W-1:0] left_q, left_d;
  logic [ZW:0]                 zi_q, zi_d;
  logic                        seg_err_q, seg_err_d;
  logic [ZW-1:0]               fin_q, fin_d;
  logic [START_W-1:0]          acc_q, acc_d;

  // word shifter
  logic [WORD_BITS-1:0]        word_q, word_d;
  logic [CNT_W-1:0]            cnt_q, cnt_d;
  logic [NW-1:0]               nres_q, nres_d;

  // output register
  logic                        ov_q, ov_d;
  logic [SW-1:0]               os_q, os_d;
  logic [zrd_pkg::COUNT_W-1:0] orep_q, orep_d;
  logic                        oend_q, oend_d;
  logic                        oerr_q, oerr_d;

  logic                        bit_av, b, out_free, put, load, accept;
  logic [ZW-1:0]               sel;
  logic [KW-1:0]               ksel;
  logic [KW-1:0]               kp1, prev_k, new_k;
  logic [zrd_pkg::COUNT_W-1:0] len;
  logic [SW-1:0]               ones;
  logic [SW-2:0]               half;
  logic                        delta_err;
  zrd_pkg::value_t             val;

  assign bit_av   = cnt_q != '0;
  assign b        = word_q[0];
  assign out_free = !ov_q || result_o.ready;
  assign put      = nres_q < NW'(zrd_pkg::MAX_RESULTS);
  assign len      = (seg_len_q == '0) ? zrd_pkg::COUNT_W'(1) : seg_len_q;
  assign stream_i.ready = (cnt_q == '0) && (phase_q != PH_FINISH) && (phase_q != PH_EMIT);
  assign accept   = stream_i.valid && stream_i.ready;

  // zone chosen by the unary prefix, last zone for escapes
  assign sel  = (unary_q < SW'(ZONE_COUNT)) ? unary_q[ZW-1:0] : ZW'(ZONE_COUNT - 1);
  assign ksel = ktab_q[sel];

  zrd_value_unit #(
    .ZONE_COUNT(ZONE_COUNT),
    .START_W   (START_W)
  ) u_value (
    .unary_i  (unary_q),
    .k_i      (ksel),
    .start_i  (start_q[sel]),
    .literal_i(lit_q),
    .value_o  (val)
  );

  // header bits assembled with the current bit
  assign kp1    = lit_q[KW-1:0] | (KW'(b) << lidx_q);
  assign prev_k = ktab_q[ZW'(zi_q - 1'b1)];

  // delta for the next zone k, from the count of ones (sign in lsb)
  always_comb begin
    ones      = (phase_q == PH_ZONE_ONES) ? unary_q : '0;
    half      = ones[SW-1:1];
    delta_err = 1'b0;
    new_k     = prev_k;
    if (ones[0]) begin
      if (SW'(half) + 1'b1 > SW'(prev_k)) begin
        new_k     = '0;
        delta_err = 1'b1;
      end else begin
        new_k = prev_k - KW'(half) - 1'b1;
      end
    end else if (SW'(half) > SW'(zrd_pkg::K_MAX) - SW'(prev_k)) begin
      new_k     = KW'(zrd_pkg::K_MAX);
      delta_err = 1'b1;
    end else begin
      new_k = prev_k + KW'(half);
    end
  end

  always_comb begin
    phase_d   = phase_q;
    ktab_d    = ktab_q;
    start_d   = start_q;
    unary_d   = unary_q;
    lit_d     = lit_q;
    lidx_d    = lidx_q;
    left_d    = left_q;
    zi_d      = zi_q;
    seg_err_d = seg_err_q;
    fin_d     = fin_q;
    acc_d     = acc_q;
    word_d    = word_q;
    cnt_d     = cnt_q;
    nres_d    = nres_q;
    load      = 1'b0;
    os_d      = os_q;
    orep_d    = orep_q;
    oend_d    = oend_q;
    oerr_d    = oerr_q;

    case (phase_q)
      PH_HEADER: begin
        if (bit_av && !((lidx_q == KW'(zrd_pkg::HEADER_BITS - 1)) && kp1 == '0 && put
                        && !out_free)) begin
          word_d = word_q >> 1;
          cnt_d  = cnt_q - 1'b1;
          if (lidx_q != KW'(zrd_pkg::HEADER_BITS - 1)) begin
            lit_d  = SW'(kp1);
            lidx_d = lidx_q + 1'b1;
          end else begin
            lit_d     = '0;
            lidx_d    = '0;
            seg_err_d = 1'b0;
            if (kp1 == '0) begin
              // silence: one zero result covering the whole segment
              load   = put;
              os_d   = '0;
              orep_d = len;
              oend_d = 1'b1;
              oerr_d = 1'b0;
              if (put) nres_d = nres_q + 1'b1;
            end else begin
              left_d = len;
              for (int z = 0; z < ZONE_COUNT; z++) ktab_d[z] = kp1 - 1'b1;
              if (zone_mode_q && len >= zrd_pkg::COUNT_W'(zrd_pkg::ZONED_MIN)) begin
                zi_d    = (ZW+1)'(1);
                unary_d = '0;
                phase_d = PH_ZONE_ONES;
              end else begin
                fin_d   = '0;
                acc_d   = '0;
                phase_d = PH_FINISH;
              end
            end
          end
        end
      end
      PH_ZONE_ONES, PH_ZONE_SECOND: begin
        if (bit_av) begin
          word_d = word_q >> 1;
          cnt_d  = cnt_q - 1'b1;
          if (phase_q == PH_ZONE_ONES && b) begin
            if (unary_q != '1) unary_d = unary_q + 1'b1;
          end else if (phase_q == PH_ZONE_ONES && unary_q == '0) begin
            phase_d = PH_ZONE_SECOND;
          end else if (phase_q == PH_ZONE_SECOND && !b) begin
            // end of list: remaining zones repeat the last k
            for (int z = 0; z < ZONE_COUNT; z++) begin
              if ((ZW+1)'(z) >= zi_q) ktab_d[z] = prev_k;
            end
            fin_d   = '0;
            acc_d   = '0;
            phase_d = PH_FINISH;
          end else begin
            ktab_d[zi_q[ZW-1:0]] = new_k;
            if (delta_err) seg_err_d = 1'b1;
            zi_d    = zi_q + 1'b1;
            unary_d = '0;
            phase_d = PH_ZONE_ONES;
            if (zi_q + 1'b1 >= (ZW+1)'(ZONE_COUNT)) begin
              fin_d   = '0;
              acc_d   = '0;
              phase_d = PH_FINISH;
            end
          end
        end
      end
      PH_UNARY: begin
        if (bit_av) begin
          word_d = word_q >> 1;
          cnt_d  = cnt_q - 1'b1;
          if (b) begin
            if (unary_q != '1) unary_d = unary_q + 1'b1;
          end else begin
            lit_d   = '0;
            lidx_d  = '0;
            phase_d = (ksel == '0) ? PH_EMIT : PH_LITERAL;
          end
        end
      end
      PH_LITERAL: begin
        if (bit_av) begin
          word_d = word_q >> 1;
          cnt_d  = cnt_q - 1'b1;
          lit_d  = lit_q | (SW'(b) << lidx_q);
          lidx_d = lidx_q + 1'b1;
          if ((KW+1)'(lidx_q) + 1'b1 >= (KW+1)'(ksel)) phase_d = PH_EMIT;
        end
      end
      PH_FINISH: begin
        // start code of each zone, one zone a cycle
        start_d[fin_q] = acc_q;
        acc_d = acc_q + (START_W'(1) << ktab_q[fin_q]);
        if (fin_q == ZW'(ZONE_COUNT - 1)) begin
          unary_d = '0;
          phase_d = PH_UNARY;
        end else begin
          fin_d = fin_q + 1'b1;
        end
      end
      PH_EMIT: begin
        if (!put || out_free) begin
          load    = put;
          os_d    = val.sample;
          orep_d  = zrd_pkg::COUNT_W'(1);
          oend_d  = (left_q - 1'b1) == '0;
          oerr_d  = seg_err_q || val.overflow;
          if (put) nres_d = nres_q + 1'b1;
          left_d  = left_q - 1'b1;
          unary_d = '0;
          lit_d   = '0;
          lidx_d  = '0;
          phase_d = ((left_q - 1'b1) == '0) ? PH_HEADER : PH_UNARY;
        end
      end
      default: phase_d = PH_HEADER;
    endcase

    if (accept) begin
      word_d = stream_i.stream_word;
      cnt_d  = CNT_W'(WORD_BITS);
      nres_d = '0;
      if (stream_i.restart) begin
        phase_d   = PH_HEADER;
        for (int z = 0; z < ZONE_COUNT; z++) begin
          ktab_d[z]  = '0;
          start_d[z] = '0;
        end
        unary_d   = '0;
        lit_d     = '0;
        lidx_d    = '0;
        left_d    = '0;
        zi_d      = '0;
        seg_err_d = 1'b0;
      end
    end

    ov_d = load ? 1'b1 : (result_o.ready ? 1'b0 : ov_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_len_q   <= zrd_pkg::COUNT_W'(256);
      zone_mode_q <= 1'b0;
      phase_q     <= PH_HEADER;
      for (int z = 0; z < ZONE_COUNT; z++) begin
        ktab_q[z]  <= '0;
        start_q[z] <= '0;
      end
      unary_q     <= '0;
      lit_q       <= '0;
      lidx_q      <= '0;
      left_q      <= '0;
      zi_q        <= '0;
      seg_err_q   <= 1'b0;
      fin_q       <= '0;
      acc_q       <= '0;
      cnt_q       <= '0;
      nres_q      <= '0;
      ov_q        <= 1'b0;
    end else begin
      if (cfg_we_i && cfg_index_i == zrd_pkg::CFG_SEG_LEN) seg_len_q <= cfg_wdata_i;
      if (cfg_we_i && cfg_index_i == zrd_pkg::CFG_ZONE_MODE) zone_mode_q <= cfg_wdata_i[0];
      phase_q   <= phase_d;
      ktab_q    <= ktab_d;
      start_q   <= start_d;
      unary_q   <= unary_d;
      lit_q     <= lit_d;
      lidx_q    <= lidx_d;
      left_q    <= left_d;
      zi_q      <= zi_d;
      seg_err_q <= seg_err_d;
      fin_q     <= fin_d;
      acc_q     <= acc_d;
      cnt_q     <= cnt_d;
      nres_q    <= nres_d;
      ov_q      <= ov_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    word_q <= word_d;
    os_q   <= os_d;
    orep_q <= orep_d;
    oend_q <= oend_d;
    oerr_q <= oerr_d;
  end

  assign result_o.valid        = ov_q;
  assign result_o.sample       = os_q;
  assign result_o.repeat_count = orep_q;
  assign result_o.segment_end  = oend_q;
  assign result_o.decode_error = oerr_q;
endmodule
